/* design/ccbi_pkg.sv */
// shared types and constants of the cell-centered bilinear interpolator
// field widths, register map, command codes and control structs; no dependencies
package ccbi_pkg;

  // fixed widths of the port fields
  localparam int COORD_W    = 17;
  localparam int IDX_W      = 8;
  localparam int DATA_W     = 32;
  localparam int SIZE_W     = 9;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // item codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // zero_axis codes
  localparam logic AXIS_Y = 1'b1;

  // register indexes, taken from paddr word bits
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ZERO_AXIS   = 2'd2;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 9'd256;

  // corners are numbered {x high, y high}
  localparam int         CORNERS     = 4;
  localparam logic [1:0] LAST_CORNER = 2'd3;

  typedef struct packed {
    logic oor;
    logic lo_edge;
    logic hi_edge;
  } axis_flags_t;

  typedef struct packed {
    logic                 wr;
    logic                 oor;
    logic [CORNERS-1:0]   zmask;
  } cmd_flags_t;

endpackage

/* design/ccbi_ram.sv */
// generic single write port, single read port memory with registered read data
// no dependencies
module ccbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ccbi_axis.sv */
// one axis of a query: range check, neighbor indexes and blend fraction
// depends on ccbi_pkg
module ccbi_axis import ccbi_pkg::*; #(
  parameter int MAX_N     = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic [COORD_W-1:0]       coord,
  input  logic [SIZE_W-1:0]        size_reg,
  output axis_flags_t              flags,
  output logic [$clog2(MAX_N)-1:0] lo_idx,
  output logic [$clog2(MAX_N)-1:0] hi_idx,
  output logic [FRAC_BITS:0]       t
);

  localparam int IW    = $clog2(MAX_N);
  localparam int TW    = FRAC_BITS + 1;
  localparam int KW    = COORD_W + 1 - FRAC_BITS;
  localparam int LIM_W = SIZE_W + FRAC_BITS;
  localparam int CMP_W = (COORD_W > LIM_W) ? COORD_W : LIM_W;
  localparam int KC_W  = (KW > SIZE_W) ? KW : SIZE_W;
  localparam logic [COORD_W:0] HALF_C = (COORD_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0]    ONE_C  = TW'(1) << FRAC_BITS;

  logic [SIZE_W-1:0]    len;
  logic [LIM_W-1:0]     limit;
  logic [COORD_W:0]     biased;
  logic [KW-1:0]        k;
  logic [FRAC_BITS-1:0] f;
  logic [TW-1:0]        f2;

  always_comb begin
    // size 0 acts as one cell, sizes above the store act as the store
    if (size_reg == '0) begin
      len = SIZE_W'(1);
    end else if (int'(size_reg) > MAX_N) begin
      len = SIZE_W'(MAX_N);
    end else begin
      len = size_reg;
    end
    limit  = {len, {FRAC_BITS{1'b0}}};
    biased = {1'b0, coord} + HALF_C;
    k      = biased[COORD_W:FRAC_BITS];
    f      = biased[FRAC_BITS-1:0];
    f2     = {f, 1'b0};

    flags.oor     = CMP_W'(coord) > CMP_W'(limit);
    flags.lo_edge = (k == '0);
    flags.hi_edge = !flags.lo_edge && (KC_W'(k) >= KC_W'(len));

    // half-cell step next to an edge doubles the fraction
    if (flags.lo_edge) begin
      lo_idx = '0;
      hi_idx = '0;
      t      = f2 - ONE_C;
    end else if (flags.hi_edge) begin
      lo_idx = IW'(len - SIZE_W'(1));
      hi_idx = IW'(len - SIZE_W'(1));
      t      = f2;
    end else begin
      lo_idx = IW'(k - KW'(1));
      hi_idx = IW'(k);
      t      = {1'b0, f};
    end
  end

endmodule

/* design/ccbi_front.sv */
// front end: classifies accepted items into queue commands
// depends on ccbi_pkg and ccbi_axis
module ccbi_front import ccbi_pkg::*; #(
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 256,
  parameter int FRAC_BITS   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        accept,
  input  logic                        mode,
  input  logic [COORD_W-1:0]          coord_x,
  input  logic [COORD_W-1:0]          coord_y,
  input  logic [IDX_W-1:0]            entry_col,
  input  logic [IDX_W-1:0]            entry_row,
  input  logic signed [DATA_W-1:0]    entry_value,
  input  logic [SIZE_W-1:0]           grid_width,
  input  logic [SIZE_W-1:0]           grid_height,
  input  logic                        zero_axis,
  output logic                        push,
  output cmd_flags_t                  flags,
  output logic [$clog2(MAX_COLS)-1:0] col_lo,
  output logic [$clog2(MAX_COLS)-1:0] col_hi,
  output logic [$clog2(MAX_ROWS)-1:0] row_lo,
  output logic [$clog2(MAX_ROWS)-1:0] row_hi,
  output logic [FRAC_BITS:0]          tx,
  output logic [FRAC_BITS:0]          ty,
  output logic [VALUE_WIDTH-1:0]      value
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  axis_flags_t   xf;
  axis_flags_t   yf;
  logic [CW-1:0] x_lo;
  logic [CW-1:0] x_hi;
  logic [RW-1:0] y_lo;
  logic [RW-1:0] y_hi;
  logic          wr_ok;

  ccbi_axis #(.MAX_N(MAX_COLS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
    .coord    (coord_x),
    .size_reg (grid_width),
    .flags    (xf),
    .lo_idx   (x_lo),
    .hi_idx   (x_hi),
    .t        (tx)
  );

  ccbi_axis #(.MAX_N(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
    .coord    (coord_y),
    .size_reg (grid_height),
    .flags    (yf),
    .lo_idx   (y_lo),
    .hi_idx   (y_hi),
    .t        (ty)
  );

  always_comb begin
    logic xe;
    logic ye;
    // writes beyond the store are dropped here
    wr_ok = (int'(entry_col) < MAX_COLS) && (int'(entry_row) < MAX_ROWS);
    push  = accept && ((mode == MODE_QUERY) || wr_ok);

    flags.wr  = (mode == MODE_WRITE);
    flags.oor = xf.oor || yf.oor;
    for (int c = 0; c < CORNERS; c++) begin
      xe = c[1] ? xf.hi_edge : xf.lo_edge;
      ye = c[0] ? yf.hi_edge : yf.lo_edge;
      flags.zmask[c] = (zero_axis == AXIS_Y) ? ye : xe;
    end

    col_lo = flags.wr ? CW'(entry_col) : x_lo;
    row_lo = flags.wr ? RW'(entry_row) : y_lo;
    col_hi = x_hi;
    row_hi = y_hi;
    value  = VALUE_WIDTH'(entry_value);
  end

endmodule

/* design/ccbi_queue.sv */
// small register queue between front and back end
// no dependencies
module ccbi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign dout  = slots[rd_ptr];
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* design/ccbi_back.sv */
// back end: grid writes, four corner reads, weighting and accumulation
// depends on ccbi_pkg; drives the grid memory ports
module ccbi_back import ccbi_pkg::*; #(
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 256,
  parameter int FRAC_BITS   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         q_empty,
  input  cmd_flags_t                                   q_flags,
  input  logic [$clog2(MAX_COLS)-1:0]                  q_col_lo,
  input  logic [$clog2(MAX_COLS)-1:0]                  q_col_hi,
  input  logic [$clog2(MAX_ROWS)-1:0]                  q_row_lo,
  input  logic [$clog2(MAX_ROWS)-1:0]                  q_row_hi,
  input  logic [FRAC_BITS:0]                           q_tx,
  input  logic [FRAC_BITS:0]                           q_ty,
  input  logic [VALUE_WIDTH-1:0]                       q_value,
  output logic                                         q_pop,
  output logic                                         ram_we,
  output logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0] ram_waddr,
  output logic [VALUE_WIDTH-1:0]                       ram_wdata,
  output logic                                         ram_re,
  output logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0] ram_raddr,
  input  logic [VALUE_WIDTH-1:0]                       ram_rdata,
  output logic                                         done,
  output logic signed [DATA_W-1:0]                     interp_value,
  output logic                                         out_of_range
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int TW    = FRAC_BITS + 1;
  localparam int WW    = 2 * FRAC_BITS + 1;
  localparam int PW    = VALUE_WIDTH + WW + 1;
  localparam int ACC_W = PW + 2;
  localparam logic [TW-1:0] ONE_C = TW'(1) << FRAC_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state;
  logic [CORNERS-1:0]        qry_zmask;
  logic [CW-1:0]             qry_col_lo;
  logic [CW-1:0]             qry_col_hi;
  logic [RW-1:0]             qry_row_lo;
  logic [RW-1:0]             qry_row_hi;
  logic [TW-1:0]             qry_tx;
  logic [TW-1:0]             qry_ty;
  logic [1:0]                iss_cnt;
  logic                      issuing;
  logic                      s1_v;
  logic                      s1_last;
  logic                      s1_zero;
  logic [WW-1:0]             s1_wt;
  logic                      s2_v;
  logic                      s2_last;
  logic signed [PW-1:0]      prod;
  logic signed [ACC_W-1:0]   acc;

  logic [TW-1:0]             wx;
  logic [TW-1:0]             wy;
  logic [WW-1:0]             wt;
  logic signed [PW-1:0]      prod_next;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]   res_shift;

  always_comb begin
    q_pop     = (state == ST_IDLE) && !q_empty;
    ram_we    = q_pop && q_flags.wr;
    ram_waddr = {q_row_lo, q_col_lo};
    ram_wdata = q_value;

    ram_re    = (state == ST_RUN) && issuing;
    ram_raddr = {iss_cnt[0] ? qry_row_hi : qry_row_lo,
                 iss_cnt[1] ? qry_col_hi : qry_col_lo};

    wx = iss_cnt[1] ? qry_tx : ONE_C - qry_tx;
    wy = iss_cnt[0] ? qry_ty : ONE_C - qry_ty;
    wt = WW'(wx) * WW'(wy);

    prod_next = s1_zero ? '0
              : PW'($signed(ram_rdata)) * PW'($signed({1'b0, s1_wt}));
    acc_sum   = acc + ACC_W'(prod);
    res_shift = acc_sum >>> (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      issuing <= 1'b0;
      iss_cnt <= '0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      s1_v <= ram_re;
      s2_v <= s1_v;
      case (state)
        ST_IDLE: begin
          if (q_pop && !q_flags.wr) begin
            if (q_flags.oor) begin
              done <= 1'b1;
            end else begin
              state   <= ST_RUN;
              issuing <= 1'b1;
              iss_cnt <= '0;
            end
          end
        end
        ST_RUN: begin
          if (issuing) begin
            iss_cnt <= iss_cnt + 2'd1;
            if (iss_cnt == LAST_CORNER) begin
              issuing <= 1'b0;
            end
          end
          if (s2_v && s2_last) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      qry_zmask  <= q_flags.zmask;
      qry_col_lo <= q_col_lo;
      qry_col_hi <= q_col_hi;
      qry_row_lo <= q_row_lo;
      qry_row_hi <= q_row_hi;
      qry_tx     <= q_tx;
      qry_ty     <= q_ty;
      interp_value <= '0;
      out_of_range <= q_flags.oor;
    end
    s1_last <= (iss_cnt == LAST_CORNER);
    s1_zero <= qry_zmask[iss_cnt];
    s1_wt   <= wt;
    s2_last <= s1_last;
    prod    <= prod_next;
    if (state == ST_IDLE) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc_sum;
    end
    if (s2_v && s2_last) begin
      interp_value <= DATA_W'(res_shift);
      out_of_range <= 1'b0;
    end
  end

endmodule

/* design/cell_centered_bilinear_interpolator_unit.sv */
// top level of the cell-centered bilinear interpolator
// depends on ccbi_pkg, ccbi_front, ccbi_queue, ccbi_back and ccbi_ram
//
// An item is taken at a rising edge with start high and busy low. A write item
// (mode 0) stores entry_value at (entry_col, entry_row) and gives no result; a
// query item (mode 1) gives one result, flagged by done for exactly one cycle.
// The receiver cannot stall, so done must be sampled every cycle. Items are
// classified on entry and parked in a two-entry queue; busy is high only while
// that queue is full. The back end drains the queue one item at a time; an
// in-range query holds it longest, bound by the single read port of the grid
// memory (four corner reads, one per cycle, then a multiply and an accumulate
// stage). Grid entries are not cleared at reset; a query must only touch
// entries that were written. Configuration (grid_width at 0x0, grid_height at
// 0x4, zero_axis at 0x8) is written through the APB port; the user must do so
// only while no item is in flight, as the block does not enforce it.
module cell_centered_bilinear_interpolator_unit import ccbi_pkg::*; #(
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 256,
  parameter int FRAC_BITS   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  // item channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode,
  input  logic [COORD_W-1:0]       coord_x,
  input  logic [COORD_W-1:0]       coord_y,
  input  logic [IDX_W-1:0]         entry_col,
  input  logic [IDX_W-1:0]         entry_row,
  input  logic signed [DATA_W-1:0] entry_value,
  // result channel
  output logic                     done,
  output logic signed [DATA_W-1:0] interp_value,
  output logic                     out_of_range,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int TW    = FRAC_BITS + 1;
  localparam int MA_W  = CW + RW;
  localparam int QW    = $bits(cmd_flags_t) + 2 * CW + 2 * RW + 2 * TW + VALUE_WIDTH;
  localparam int Q_DEPTH = 2;

  // configuration registers
  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic              zero_axis;
  logic              cfg_wr;

  // front end to queue
  logic                   accept;
  logic                   q_push;
  cmd_flags_t             f_flags;
  logic [CW-1:0]          f_col_lo;
  logic [CW-1:0]          f_col_hi;
  logic [RW-1:0]          f_row_lo;
  logic [RW-1:0]          f_row_hi;
  logic [TW-1:0]          f_tx;
  logic [TW-1:0]          f_ty;
  logic [VALUE_WIDTH-1:0] f_value;
  logic [QW-1:0]          q_din;

  // queue to back end
  logic [QW-1:0]          q_dout;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_pop;
  cmd_flags_t             h_flags;
  logic [CW-1:0]          h_col_lo;
  logic [CW-1:0]          h_col_hi;
  logic [RW-1:0]          h_row_lo;
  logic [RW-1:0]          h_row_hi;
  logic [TW-1:0]          h_tx;
  logic [TW-1:0]          h_ty;
  logic [VALUE_WIDTH-1:0] h_value;

  // grid memory
  logic                   ram_we;
  logic [MA_W-1:0]        ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [MA_W-1:0]        ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // apb register access, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIZE_RESET;
      grid_height <= GRID_SIZE_RESET;
      zero_axis   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GRID_WIDTH:  grid_width  <= pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[SIZE_W-1:0];
        REG_ZERO_AXIS:   zero_axis   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRID_WIDTH:  prdata = CFG_DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = CFG_DATA_W'(grid_height);
      REG_ZERO_AXIS:   prdata = CFG_DATA_W'(zero_axis);
      default:         prdata = '0;
    endcase
  end

  // item handshake: the queue having room is the only back pressure
  assign busy   = q_full;
  assign accept = start && !busy;

  ccbi_front #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .accept      (accept),
    .mode        (mode),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .entry_col   (entry_col),
    .entry_row   (entry_row),
    .entry_value (entry_value),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .zero_axis   (zero_axis),
    .push        (q_push),
    .flags       (f_flags),
    .col_lo      (f_col_lo),
    .col_hi      (f_col_hi),
    .row_lo      (f_row_lo),
    .row_hi      (f_row_hi),
    .tx          (f_tx),
    .ty          (f_ty),
    .value       (f_value)
  );

  // command word layout shared by both ends of the queue
  assign q_din = {f_flags, f_col_lo, f_col_hi, f_row_lo, f_row_hi, f_tx, f_ty, f_value};
  assign {h_flags, h_col_lo, h_col_hi, h_row_lo, h_row_hi, h_tx, h_ty, h_value} = q_dout;

  ccbi_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  ccbi_back #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_flags      (h_flags),
    .q_col_lo     (h_col_lo),
    .q_col_hi     (h_col_hi),
    .q_row_lo     (h_row_lo),
    .q_row_hi     (h_row_hi),
    .q_tx         (h_tx),
    .q_ty         (h_ty),
    .q_value      (h_value),
    .q_pop        (q_pop),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .done         (done),
    .interp_value (interp_value),
    .out_of_range (out_of_range)
  );

  // grid store, row-major with power-of-two row pitch
  ccbi_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (2 ** MA_W)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTH
  // an out-of-range result always carries a zero value
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (interp_value == '0))
    else $error("out-of-range result with nonzero value");

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue overflow");

  // the back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue underflow");

  // grid writes and corner reads never share a cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("grid write during corner read");
`endif

endmodule

/* verif/ccbi_interp_checker.sv */
// checker for the cell-centered bilinear interpolator: watches the item, result and
// register channels, predicts every query result and compares it; depends on ccbi_pkg
module ccbi_interp_checker import ccbi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     mode,
  input  logic [COORD_W-1:0]       coord_x,
  input  logic [COORD_W-1:0]       coord_y,
  input  logic [IDX_W-1:0]         entry_col,
  input  logic [IDX_W-1:0]         entry_row,
  input  logic signed [DATA_W-1:0] entry_value,
  input  logic                     done,
  input  logic signed [DATA_W-1:0] interp_value,
  input  logic                     out_of_range,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  input  logic                     pready,
  output int                       outstanding,
  output int                       fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_DIM   = 256;
  localparam int FRAC       = 8;
  localparam int CELL       = 1 << FRAC;
  localparam int HALF_CELL  = 1 << (FRAC - 1);
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [COORD_W-1:0]       cx;
    logic [COORD_W-1:0]       cy;
    logic signed [DATA_W-1:0] value;
    logic                     oor;
  } interp_result_t;

  logic signed [DATA_W-1:0] grid_mem [0:GRID_DIM*GRID_DIM-1];
  logic [SIZE_W-1:0]        width_reg;
  logic [SIZE_W-1:0]        height_reg;
  logic                     zaxis_reg;
  interp_result_t           pending_interp[$];
  int                       failures;

  function automatic int cells_in_use(logic [SIZE_W-1:0] r);
    if (r == 0) return 1;
    return (int'(r) > GRID_DIM) ? GRID_DIM : int'(r);
  endfunction

  // neighbor indices, edge flags and weight of the upper neighbor along one axis
  function automatic void locate_cells(input int c, input int len, output int lo, output int hi,
                                       output bit lo_e, output bit hi_e, output int t);
    int k;
    k = (c + HALF_CELL) >> FRAC;
    lo_e = 1'b0;
    hi_e = 1'b0;
    if (k == 0) begin
      lo_e = 1'b1;
      lo = 0;
      hi = 0;
      t = 2 * c;
    end else if (k >= len) begin
      hi_e = 1'b1;
      lo = len - 1;
      hi = len - 1;
      t = 2 * (c - (len * CELL - HALF_CELL));
    end else begin
      lo = k - 1;
      hi = k;
      t = c - (k * CELL - HALF_CELL);
    end
  endfunction

  function automatic interp_result_t bilinear_at(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    interp_result_t r;
    int w, h, xlo, xhi, ylo, yhi, tx, ty, wx, wy, col, row;
    bit xlo_e, xhi_e, ylo_e, yhi_e, xe, ye;
    logic signed [DATA_W-1:0] v;
    longint acc;
    w = cells_in_use(width_reg);
    h = cells_in_use(height_reg);
    r.cx = cx;
    r.cy = cy;
    r.value = '0;
    r.oor = 1'b0;
    if (int'(cx) > w * CELL || int'(cy) > h * CELL) begin
      r.oor = 1'b1;
      return r;
    end
    locate_cells(int'(cx), w, xlo, xhi, xlo_e, xhi_e, tx);
    locate_cells(int'(cy), h, ylo, yhi, ylo_e, yhi_e, ty);
    acc = 0;
    for (int xi = 0; xi < 2; xi++) begin
      for (int yi = 0; yi < 2; yi++) begin
        wx = xi ? tx : CELL - tx;
        wy = yi ? ty : CELL - ty;
        col = xi ? xhi : xlo;
        row = yi ? yhi : ylo;
        xe = xi ? xhi_e : xlo_e;
        ye = yi ? yhi_e : ylo_e;
        // edge value forced to zero on the selected axis only
        if ((zaxis_reg == AXIS_Y) ? ye : xe) v = '0;
        else v = grid_mem[row * GRID_DIM + col];
        acc += longint'(v) * longint'(wx * wy);
      end
    end
    acc = acc >>> (2 * FRAC);
    r.value = acc[DATA_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    interp_result_t want;
    if (rst) begin
      width_reg = GRID_SIZE_RESET;
      height_reg = GRID_SIZE_RESET;
      zaxis_reg = 1'b0;
      pending_interp.delete();
      failures = 0;
    end else begin
      if (done) begin
        if (pending_interp.size() == 0) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("%0t: result with no query waiting: interp_value %h out_of_range %b",
                     $realtime, interp_value, out_of_range);
        end else begin
          want = pending_interp.pop_front();
          if (interp_value !== want.value || out_of_range !== want.oor) begin
            failures++;
            if (failures <= REPORT_MAX)
              $display("%0t: query (%0d,%0d): exp value %h oor %b, got value %h oor %b",
                       $realtime, want.cx, want.cy, want.value, want.oor,
                       interp_value, out_of_range);
          end
        end
      end
      if (start && !busy) begin
        if (mode == MODE_WRITE) grid_mem[{entry_row, entry_col}] = entry_value;
        else pending_interp.push_back(bilinear_at(coord_x, coord_y));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GRID_WIDTH:  width_reg = pwdata[SIZE_W-1:0];
          REG_GRID_HEIGHT: height_reg = pwdata[SIZE_W-1:0];
          REG_ZERO_AXIS:   zaxis_reg = pwdata[0];
          default: ;
        endcase
      end
    end
    outstanding <= pending_interp.size();
    fail_count <= failures;
  end

endmodule

/* verif/cell_centered_bilinear_interpolator_unit_tb.sv */
// testbench top for the cell-centered bilinear interpolator: clock, reset, register
// setup and item stimulus; depends on ccbi_pkg, ccbi_interp_checker and the block itself
module cell_centered_bilinear_interpolator_unit_tb import ccbi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_DIM      = 256;
  localparam int FRAC          = 8;
  localparam int CELL          = 1 << FRAC;
  localparam int HALF_CELL     = 1 << (FRAC - 1);
  localparam int COORD_MAX     = 65536;
  localparam int PHASES        = 8;
  localparam int SEQS_PER_PHASE = 44;
  // quiet time before a register write, sized for two parked items plus one in the
  // back end to finish
  localparam int SETTLE_CYCLES = 24;
  localparam int END_CYCLES    = 30;
  // longest correct stretch without any handshake is a sender gap plus the queued
  // queries, or the settle pause; this is many times that
  localparam int STALL_LIMIT   = 2000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     mode = MODE_WRITE;
  logic [COORD_W-1:0]       coord_x = '0;
  logic [COORD_W-1:0]       coord_y = '0;
  logic [IDX_W-1:0]         entry_col = '0;
  logic [IDX_W-1:0]         entry_row = '0;
  logic signed [DATA_W-1:0] entry_value = '0;
  logic                     done;
  logic signed [DATA_W-1:0] interp_value;
  logic                     out_of_range;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]    paddr = '0;
  logic [CFG_DATA_W-1:0]    pwdata = '0;
  logic [CFG_DATA_W-1:0]    prdata;
  logic                     pready;

  int outstanding;
  int fail_count;
  int stall_cycles = 0;

  // stimulus bookkeeping: which grid entries hold a value, and the sizes in use
  bit written [0:GRID_DIM-1][0:GRID_DIM-1];
  int eff_w = GRID_DIM;
  int eff_h = GRID_DIM;
  bit gaps_on = 1'b1;
  int n_writes = 0;
  int n_queries = 0;
  int n_outside = 0;
  int n_settings = 1;

  always #2 clk = ~clk;

  cell_centered_bilinear_interpolator_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .entry_col    (entry_col),
    .entry_row    (entry_row),
    .entry_value  (entry_value),
    .done         (done),
    .interp_value (interp_value),
    .out_of_range (out_of_range),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  ccbi_interp_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .entry_col    (entry_col),
    .entry_row    (entry_row),
    .entry_value  (entry_value),
    .done         (done),
    .interp_value (interp_value),
    .out_of_range (out_of_range),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  // watchdog: any item, result or register access counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results still due",
                 STALL_LIMIT, outstanding);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // one item on the command channel; returns at the edge that takes it, with start
  // left high so a following item can go out back to back
  task automatic send_item(logic m, int cx, int cy, int col, int row, logic [31:0] val);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    start <= 1'b1;
    mode <= m;
    coord_x <= COORD_W'(cx);
    coord_y <= COORD_W'(cy);
    entry_col <= IDX_W'(col);
    entry_row <= IDX_W'(row);
    entry_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random grid value, with the signed extremes and zero now and then
  function automatic logic [31:0] grid_value();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_entry(int col, int row, logic [31:0] val);
    // coordinates are don't-care on a write, so they get random bits
    send_item(MODE_WRITE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
              col, row, val);
    written[row][col] = 1'b1;
    n_writes++;
  endtask

  task automatic ensure_written(int col, int row);
    if (!written[row][col]) write_entry(col, row, grid_value());
  endtask

  // which two cells a coordinate falls between along one axis
  function automatic void cell_span(input int c, input int len, output int lo, output int hi);
    int k;
    k = (c + HALF_CELL) >> FRAC;
    if (k == 0) begin
      lo = 0;
      hi = 0;
    end else if (k >= len) begin
      lo = len - 1;
      hi = len - 1;
    end else begin
      lo = k - 1;
      hi = k;
    end
  endfunction

  // a query item, preceded by writes of any neighbor that never got a value
  task automatic query_at(int cx, int cy);
    int xlo, xhi, ylo, yhi;
    if (cx <= eff_w * CELL && cy <= eff_h * CELL) begin
      cell_span(cx, eff_w, xlo, xhi);
      cell_span(cy, eff_h, ylo, yhi);
      ensure_written(xlo, ylo);
      ensure_written(xhi, ylo);
      ensure_written(xlo, yhi);
      ensure_written(xhi, yhi);
    end else begin
      n_outside++;
    end
    send_item(MODE_QUERY, cx, cy, $urandom_range(0, GRID_DIM - 1),
              $urandom_range(0, GRID_DIM - 1), $urandom);
    n_queries++;
  endtask

  // coordinate inside the grid, biased toward the half-cell edge strips and toward
  // exact centers and cell borders
  function automatic int pick_coord(int len);
    int span;
    span = len * CELL;
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, HALF_CELL + 20);
      1: return span - $urandom_range(0, HALF_CELL + 20);
      2: return $urandom_range(0, 2 * len) * HALF_CELL;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  function automatic int cells_in_use(int r);
    if (r == 0) return 1;
    return (r > GRID_DIM) ? GRID_DIM : r;
  endfunction

  // stop sending, then wait for every result plus a margin for trailing writes
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] word);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // new grid size and zero axis, written only once the block has gone quiet;
  // bits above the register width carry random junk
  task automatic set_grid(int w, int h, logic z);
    logic [31:0] word;
    drain();
    word = $urandom;
    word[SIZE_W-1:0] = SIZE_W'(w);
    apb_write(REG_GRID_WIDTH, word);
    word = $urandom;
    word[SIZE_W-1:0] = SIZE_W'(h);
    apb_write(REG_GRID_HEIGHT, word);
    word = $urandom;
    word[0] = z;
    apb_write(REG_ZERO_AXIS, word);
    eff_w = cells_in_use(w & 9'h1FF);
    eff_h = cells_in_use(h & 9'h1FF);
    n_settings++;
  endtask

  initial begin
    int w_sel, h_sel;
    logic z_sel;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes, zero_axis on x: extreme values around the lower corner
    write_entry(0, 0, 32'h7FFF_FFFF);
    write_entry(1, 0, 32'h8000_0000);
    write_entry(0, 1, 32'h8000_0000);
    write_entry(1, 1, 32'hFFFF_FFFF);
    query_at(0, 0);                    // lower corner, both axes in the edge strip
    query_at(256, 256);                // midway between the first four centers
    query_at(128, 383);
    query_at(COORD_MAX, COORD_MAX);    // upper corner, coordinate msb set
    query_at(COORD_MAX, 0);
    query_at(0, COORD_MAX);

    // small grid, zero_axis on y: exact bounds and just past them
    set_grid(3, 2, AXIS_Y);
    query_at(3 * CELL, 2 * CELL);
    query_at(3 * CELL + 1, 0);
    query_at(0, 2 * CELL + 1);
    query_at(COORD_MAX, COORD_MAX);
    query_at(640, 300);

    for (int p = 0; p < PHASES; p++) begin
      // the last phase runs with the sender never idle
      gaps_on = (p != PHASES - 1);
      case (p)
        0: set_grid(GRID_DIM, GRID_DIM, AXIS_Y);
        1: set_grid(1, 1, ~AXIS_Y);
        2: set_grid(0, 0, AXIS_Y);                 // zero size acts as one cell
        3: set_grid(511, 300, ~AXIS_Y);            // oversize acts as full grid
        4: set_grid(2, GRID_DIM, AXIS_Y);
        5: set_grid(GRID_DIM, 1, ~AXIS_Y);
        6: begin
          w_sel = $urandom_range(1, 16);
          h_sel = $urandom_range(1, 16);
          z_sel = $urandom_range(0, 1);
          set_grid(w_sel, h_sel, z_sel);
        end
        default: begin
          w_sel = $urandom_range(0, 511);
          h_sel = $urandom_range(0, 511);
          z_sel = $urandom_range(0, 1);
          set_grid(w_sel, h_sel, z_sel);
        end
      endcase
      for (int n = 0; n < SEQS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          // stray write anywhere, also beyond the size in use
          0, 1: write_entry($urandom_range(0, GRID_DIM - 1), $urandom_range(0, GRID_DIM - 1),
                            grid_value());
          2: begin
            // outside the grid on one axis where the size leaves room for it
            if (eff_w < GRID_DIM && (eff_h == GRID_DIM || $urandom_range(0, 1) == 0))
              query_at($urandom_range(eff_w * CELL + 1, COORD_MAX),
                       $urandom_range(0, COORD_MAX));
            else if (eff_h < GRID_DIM)
              query_at($urandom_range(0, COORD_MAX),
                       $urandom_range(eff_h * CELL + 1, COORD_MAX));
            else
              query_at(pick_coord(eff_w), pick_coord(eff_h));
          end
          default: query_at(pick_coord(eff_w), pick_coord(eff_h));
        endcase
      end
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d grid writes and %0d queries, %0d of them outside the grid,",
             n_writes, n_queries, n_outside);
    $display("under %0d grid size and zero axis settings", n_settings);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
